// ===== rtl/hfp_pkg.sv =====
// ----------------------------------------------------------------------------
// hfp_pkg: shared definitions for the heartbeat frame parser
// Frame constants, register indexes, the CRC-16 byte update and the
// structs that pass between the collector and the top level.
// ----------------------------------------------------------------------------
package hfp_pkg;

  localparam logic [7:0]  SYNC_A        = 8'hA5;
  localparam logic [7:0]  SYNC_B        = 8'h5A;
  localparam logic [7:0]  PROTO_VERSION = 8'h01;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_HEARTBEAT_CODE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACKNOWLEDGE_CODE = 1'd1;

  localparam logic [7:0] HEARTBEAT_CODE_RST   = 8'h00;
  localparam logic [7:0] ACKNOWLEDGE_CODE_RST = 8'h01;

  // Byte positions within the 8-byte frame.
  localparam logic [2:0] POS_SYNC_A  = 3'd0;
  localparam logic [2:0] POS_SYNC_B  = 3'd1;
  localparam logic [2:0] POS_VERSION = 3'd2;
  localparam logic [2:0] POS_KIND    = 3'd3;
  localparam logic [2:0] POS_SEQ_LO  = 3'd4;
  localparam logic [2:0] POS_SEQ_HI  = 3'd5;
  localparam logic [2:0] POS_CRC_LO  = 3'd6;
  localparam logic [2:0] POS_CRC_HI  = 3'd7;

  // A frame that passed the sync, version and CRC checks.
  typedef struct packed {
    logic        done;
    logic [7:0]  kind;
    logic [15:0] sequence_num;
  } frame_t;

  typedef struct packed {
    logic hunting;
    logic at_last;
  } coll_status_t;

  typedef struct packed {
    logic [7:0]  kind;
    logic [15:0] sequence_num;
  } msg_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/hfp_byte_if.sv =====
// ----------------------------------------------------------------------------
// hfp_byte_if: received byte channel
// Valid/ready channel that carries one received serial byte per beat.
// ----------------------------------------------------------------------------
interface hfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/hfp_msg_if.sv =====
// ----------------------------------------------------------------------------
// hfp_msg_if: decoded message channel
// Valid/ready channel that carries one validated message per beat.
// ----------------------------------------------------------------------------
interface hfp_msg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  msg_kind;
  logic [15:0] msg_sequence;

  modport source (output valid, output msg_kind, output msg_sequence, input ready);
  modport sink   (input valid, input msg_kind, input msg_sequence, output ready);
endinterface

// ===== rtl/hfp_collector.sv =====
// ----------------------------------------------------------------------------
// hfp_collector: sync hunt and frame collection
// Tracks the position in the frame, keeps the fields and a running CRC,
// and flags a frame whose sync, version and CRC are all good.
// ----------------------------------------------------------------------------
module hfp_collector (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_en,
  input  logic [7:0]            rx_byte,
  output hfp_pkg::frame_t       frame,
  output hfp_pkg::coll_status_t status
);
  import hfp_pkg::*;

  logic [2:0]  fill_count;
  logic [2:0]  fill_count_next;
  logic [15:0] crc;
  logic [15:0] crc_base;
  logic [7:0]  version;
  logic [7:0]  kind;
  logic [7:0]  seq_lo;
  logic [7:0]  seq_hi;
  logic [7:0]  crc_lo;

  // A new first sync byte restarts the CRC from its initial value.
  assign crc_base = ((fill_count == POS_SYNC_A) ||
                     ((fill_count == POS_SYNC_B) && (rx_byte != SYNC_B))) ?
                    CRC_INIT : crc;

  always_comb begin
    fill_count_next = fill_count;
    case (fill_count)
      POS_SYNC_A: begin
        if (rx_byte == SYNC_A) fill_count_next = POS_SYNC_B;
      end
      POS_SYNC_B: begin
        if (rx_byte == SYNC_B) begin
          fill_count_next = POS_VERSION;
        end else if (rx_byte == SYNC_A) begin
          fill_count_next = POS_SYNC_B;
        end else begin
          fill_count_next = POS_SYNC_A;
        end
      end
      default: fill_count_next = fill_count + 3'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= POS_SYNC_A;
    end else if (byte_en) begin
      fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en) begin
      if (fill_count < POS_CRC_LO) crc <= crc16_update(crc_base, rx_byte);
      if (fill_count == POS_VERSION) version <= rx_byte;
      if (fill_count == POS_KIND)    kind    <= rx_byte;
      if (fill_count == POS_SEQ_LO)  seq_lo  <= rx_byte;
      if (fill_count == POS_SEQ_HI)  seq_hi  <= rx_byte;
      if (fill_count == POS_CRC_LO)  crc_lo  <= rx_byte;
    end
  end

  assign frame.done = byte_en && (fill_count == POS_CRC_HI) &&
                      (version == PROTO_VERSION) && ({rx_byte, crc_lo} == crc);
  assign frame.kind         = kind;
  assign frame.sequence_num = {seq_hi, seq_lo};

  assign status.hunting = (fill_count == POS_SYNC_A);
  assign status.at_last = (fill_count == POS_CRC_HI);

endmodule

// ===== rtl/hfp_out_stage.sv =====
// ----------------------------------------------------------------------------
// hfp_out_stage: message result register
// Holds one message until the receiver takes it.
// ----------------------------------------------------------------------------
module hfp_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  hfp_pkg::msg_t data,
  hfp_msg_if.source     msg
);
  import hfp_pkg::*;

  logic valid;
  msg_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (msg.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= data;
  end

  assign msg.valid        = valid;
  assign msg.msg_kind     = held.kind;
  assign msg.msg_sequence = held.sequence_num;

endmodule

// ===== rtl/heartbeat_frame_parser.sv =====
// ----------------------------------------------------------------------------
// heartbeat_frame_parser: sync-word frame parser with CRC-16 check
// Hunts for the 0xA5 0x5A sync pair in a byte stream, collects 8-byte
// frames and passes on heartbeat and acknowledge messages.
// ----------------------------------------------------------------------------
// Usage:
// The rx channel takes one received byte per beat. The msg channel gives
// one beat per valid frame, carrying the kind byte and the 16-bit sequence
// number. A frame is passed on when its version is 1, its CRC-16/CCITT-FALSE
// (sent low byte first) matches bytes 0 to 5, and its kind equals one of the
// two configured codes. The codes are written through cfg_en, cfg_index and
// cfg_data while the parser is idle.
// Throughput is one byte per cycle while rx.ready is high. The message
// appears on msg in the cycle after the last frame byte is taken; the work
// per byte is the running CRC update of one byte and the final compares.
// Reset clears the collector to hunting, empties the result register and
// returns the codes to heartbeat 0x00 and acknowledge 0x01.
// While the receiver stalls a held message, bytes keep flowing in; only the
// last byte of a frame waits until the result register is free.
// ----------------------------------------------------------------------------
module heartbeat_frame_parser (
  input  logic                            clk,
  input  logic                            rst,
  hfp_byte_if.sink                        rx,
  hfp_msg_if.source                       msg,
  input  logic                            cfg_en,
  input  logic [hfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hfp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hfp_pkg::*;

  logic [7:0]   heartbeat_code;
  logic [7:0]   acknowledge_code;
  logic         byte_en;
  logic         kind_ok;
  frame_t       frame;
  coll_status_t status;
  msg_t         msg_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      heartbeat_code   <= HEARTBEAT_CODE_RST;
      acknowledge_code <= ACKNOWLEDGE_CODE_RST;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_HEARTBEAT_CODE:   heartbeat_code   <= cfg_data;
        REG_ACKNOWLEDGE_CODE: acknowledge_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Only the closing byte of a frame can produce a message, so it alone
  // waits on a stalled result register.
  assign rx.ready = !status.at_last || !msg.valid || msg.ready;
  assign byte_en  = rx.valid && rx.ready;

  hfp_collector u_collector (
    .clk     (clk),
    .rst     (rst),
    .byte_en (byte_en),
    .rx_byte (rx.rx_byte),
    .frame   (frame),
    .status  (status)
  );

  assign kind_ok = (frame.kind == heartbeat_code) || (frame.kind == acknowledge_code);
  assign msg_data.kind         = frame.kind;
  assign msg_data.sequence_num = frame.sequence_num;

  hfp_out_stage u_out_stage (
    .clk  (clk),
    .rst  (rst),
    .load (frame.done && kind_ok),
    .data (msg_data),
    .msg  (msg)
  );

  // A new message only follows the closing byte of a frame.
  a_msg_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(msg.valid) |-> $past(rx.valid && rx.ready && status.at_last))
    else $error("message raised without a closing frame byte");

  // The closing byte always returns the collector to hunting.
  a_hunt_after_frame: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready && status.at_last) |=> status.hunting)
    else $error("collector did not resume hunting after a frame");

  // While hunting, anything but the first sync byte is ignored.
  a_hunt_ignores: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready && status.hunting && (rx.rx_byte != SYNC_A))
      |=> status.hunting)
    else $error("collector left hunting without a sync byte");

endmodule

// ===== dv/heartbeat_frame_parser_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heartbeat_frame_parser_test: self-checking bench for the frame parser
// Feeds received bytes (clean frames, corrupted frames, truncated frames,
// false sync starts and line noise) through the rx channel with random
// bursts and gaps. The msg channel stalls on its own pattern. A bench-side
// parser predicts every message, and each msg beat is compared with the
// oldest prediction. The kind codes are rewritten between phases.
// ----------------------------------------------------------------------------
module heartbeat_frame_parser_test;
  import hfp_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   cfg_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  hfp_byte_if rx ();
  hfp_msg_if  msg ();

  heartbeat_frame_parser dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx.sink),
    .msg       (msg.source),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Bytes still to be sent, and messages the bench parser says must come out.
  logic [7:0] rx_backlog[$];
  msg_t       awaited_msgs[$];
  int         mismatch_count = 0;

  // Bench copy of the parser state and of the two kind codes.
  logic [2:0] bytes_held = 3'd0;
  logic [7:0] frame_bytes[8];
  logic [7:0] hb_code;
  logic [7:0] ack_code;

  // Sender burst shaping and receiver stall pattern.
  int burst_left;
  int gap_left;
  int ready_mode;
  int mode_left;
  int stall_left;

  // One byte of CRC-16/CCITT-FALSE, most significant bit first.
  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc,
                                                 input logic [7:0]  b);
    acc = acc ^ {b, 8'h00};
    repeat (8) begin
      acc = acc[15] ? ({acc[14:0], 1'b0} ^ CRC_POLY) : {acc[14:0], 1'b0};
    end
    return acc;
  endfunction

  // Advances the bench parser by one received byte. Returns 1 when the byte
  // completes a frame that passes the version, CRC and kind checks.
  function automatic bit parse_rx_byte(input logic [7:0] b, output msg_t m);
    logic [15:0] crc;
    m = '0;
    // While hunting, anything but the first sync byte is dropped.
    if (bytes_held == 3'd0 && b != SYNC_A) begin
      return 0;
    end
    // A wrong second sync byte restarts the hunt, but a fresh first sync
    // byte counts as the start of a new pair.
    if (bytes_held == 3'd1 && b != SYNC_B) begin
      bytes_held = (b == SYNC_A) ? 3'd1 : 3'd0;
      return 0;
    end
    frame_bytes[bytes_held] = b;
    bytes_held = bytes_held + 3'd1;
    // The count wraps to zero on the eighth byte, so the collector goes
    // back to hunting whether or not the frame is good.
    if (bytes_held != 3'd0) begin
      return 0;
    end
    if (frame_bytes[POS_VERSION] != PROTO_VERSION) begin
      return 0;
    end
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc = crc_ccitt_step(crc, frame_bytes[i]);
    end
    if (crc != {frame_bytes[POS_CRC_HI], frame_bytes[POS_CRC_LO]}) begin
      return 0;
    end
    if (frame_bytes[POS_KIND] != hb_code && frame_bytes[POS_KIND] != ack_code) begin
      return 0;
    end
    m.kind         = frame_bytes[POS_KIND];
    m.sequence_num = {frame_bytes[POS_SEQ_HI], frame_bytes[POS_SEQ_LO]};
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    // Only the first 40 are printed so a broken block cannot flood the log.
    if (mismatch_count < 40) begin
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
    mismatch_count++;
  endtask

  // Queues the first keep bytes of a frame. A nonzero crc_flip corrupts the
  // check word that goes out on the wire.
  task automatic queue_frame(input logic [7:0] ver, input logic [7:0] kind_b,
                             input logic [15:0] seq, input logic [15:0] crc_flip,
                             input int keep);
    logic [7:0]  fb[8];
    logic [15:0] crc;
    fb[0] = SYNC_A;
    fb[1] = SYNC_B;
    fb[2] = ver;
    fb[3] = kind_b;
    fb[4] = seq[7:0];
    fb[5] = seq[15:8];
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc = crc_ccitt_step(crc, fb[i]);
    end
    crc = crc ^ crc_flip;
    fb[6] = crc[7:0];
    fb[7] = crc[15:8];
    for (int i = 0; i < keep; i++) begin
      rx_backlog.push_back(fb[i]);
    end
  endtask

  // Mostly one of the two live codes, sometimes any byte at all.
  function automatic logic [7:0] pick_kind();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom);
      1, 2, 3,
      4:       return hb_code;
      default: return ack_code;
    endcase
  endfunction

  function automatic logic [15:0] pick_seq();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Fills the backlog with about n_bytes of traffic. Most of it is clean
  // frames, so the collector reaches the decode step often; the rest is
  // corrupted or cut-off frames, false sync starts and line noise.
  task automatic queue_random_traffic(input int n_bytes);
    int         start_len;
    logic [7:0] b;
    start_len = rx_backlog.size();
    while (rx_backlog.size() - start_len < n_bytes) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          queue_frame(PROTO_VERSION, pick_kind(), pick_seq(), 16'h0000, 8);
        end
        11, 12: begin
          queue_frame(8'($urandom), pick_kind(), pick_seq(), 16'h0000, 8);
        end
        13, 14: begin
          queue_frame(PROTO_VERSION, pick_kind(), pick_seq(),
                      16'($urandom_range(1, 16'hFFFF)), 8);
        end
        15: begin
          // A cut-off frame swallows the head of whatever follows it.
          queue_frame(PROTO_VERSION, pick_kind(), pick_seq(), 16'h0000,
                      $urandom_range(2, 7));
        end
        16, 17: begin
          repeat ($urandom_range(1, 6)) rx_backlog.push_back(8'($urandom));
        end
        18: begin
          // First sync byte followed by something other than the second.
          do begin
            b = 8'($urandom);
          end while (b == SYNC_B);
          rx_backlog.push_back(SYNC_A);
          rx_backlog.push_back(b);
        end
        default: begin
          rx_backlog.push_back(SYNC_A);
          queue_frame(PROTO_VERSION, pick_kind(), pick_seq(), 16'h0000, 8);
        end
      endcase
    end
  endtask

  task automatic write_code(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_HEARTBEAT_CODE:   hb_code  = val;
      REG_ACKNOWLEDGE_CODE: ack_code = val;
      default: ;
    endcase
  endtask

  task automatic set_codes(input logic [7:0] hb, input logic [7:0] ack);
    write_code(REG_HEARTBEAT_CODE, hb);
    write_code(REG_ACKNOWLEDGE_CODE, ack);
    @(posedge clk);
    cfg_en <= 1'b0;
  endtask

  // Waits until every byte has gone in and every awaited message has come
  // out, then waits out the settle time. A partial frame may still sit in the
  // collector, which the settle time covers. Checked on the falling edge so
  // the driver's updates at the rising edge have landed.
  task automatic drain(input int settle);
    @(negedge clk);
    while (rx_backlog.size() != 0 || rx.valid || awaited_msgs.size() != 0) begin
      @(negedge clk);
    end
    repeat (settle) @(posedge clk);
  endtask

  // Sender: presents the next byte when the channel is free, in bursts of
  // random length with random gaps. Every accepted beat goes through the
  // bench parser right away.
  always @(posedge clk) begin
    msg_t m;
    if (rst) begin
      rx.valid   <= 1'b0;
      rx.rx_byte <= 8'h00;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (rx.valid && rx.ready) begin
        if (parse_rx_byte(rx.rx_byte, m)) begin
          awaited_msgs.push_back(m);
        end
      end
      if (!rx.valid || rx.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          rx.valid <= 1'b0;
        end else if (rx_backlog.size() != 0) begin
          rx.valid   <= 1'b1;
          rx.rx_byte <= rx_backlog.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          rx.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each msg beat against the oldest prediction, and drives
  // ready in modes chosen at random: always ready, coin-flip ready, and long
  // stalls now and then.
  always @(posedge clk) begin
    msg_t want;
    if (rst) begin
      msg.ready  <= 1'b0;
      ready_mode <= 0;
      mode_left  <= 0;
      stall_left <= 0;
    end else begin
      if (msg.valid && msg.ready) begin
        if (awaited_msgs.size() == 0) begin
          report_mismatch("msg beat with none awaited, kind", 0, msg.msg_kind);
        end else begin
          want = awaited_msgs.pop_front();
          if (msg.msg_kind !== want.kind) begin
            report_mismatch("msg_kind", want.kind, msg.msg_kind);
          end
          if (msg.msg_sequence !== want.sequence_num) begin
            report_mismatch("msg_sequence", want.sequence_num, msg.msg_sequence);
          end
        end
      end
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: msg.ready <= 1'b1;
        1: msg.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            msg.ready  <= 1'b0;
          end else begin
            msg.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
              stall_left <= $urandom_range(5, 25);
            end
          end
        end
      endcase
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_en         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    hb_code        = HEARTBEAT_CODE_RST;
    ack_code       = ACKNOWLEDGE_CODE_RST;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run on the reset codes (heartbeat 0x00, ack 0x01).
    // Noise while hunting is ignored.
    rx_backlog.push_back(8'h00);
    rx_backlog.push_back(8'hFF);
    // A doubled first sync byte: the second one starts the pair. The frame
    // carries the heartbeat code and the top sequence number.
    rx_backlog.push_back(SYNC_A);
    queue_frame(PROTO_VERSION, 8'h00, 16'hFFFF, 16'h0000, 8);
    // A wrong second sync byte that is not a first sync byte drops the hunt.
    rx_backlog.push_back(SYNC_A);
    rx_backlog.push_back(8'h33);
    // An acknowledgement with sequence zero, then another one with a bad CRC.
    queue_frame(PROTO_VERSION, 8'h01, 16'h0000, 16'h0000, 8);
    queue_frame(PROTO_VERSION, 8'h01, 16'h1234, 16'h8001, 8);
    drain(5);

    // Random phases, each under its own pair of codes: the extremes, both
    // codes equal, and random values.
    set_codes(8'hFF, 8'h00);
    queue_random_traffic(320);
    drain(5);

    set_codes(8'h7E, 8'h7E);
    queue_random_traffic(320);
    drain(5);

    set_codes(8'($urandom), 8'($urandom));
    queue_random_traffic(320);
    drain(5);

    set_codes(8'h00, 8'hFF);
    queue_random_traffic(320);
    drain(5);

    set_codes(8'($urandom), 8'($urandom));
    queue_random_traffic(320);
    drain(10);

    if (mismatch_count == 0 && awaited_msgs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: the slowest correct run takes well under a tenth of this.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
